/* sv/dmf_pkg.sv */
// shared types and constants for the duplicate message filter
`default_nettype none

package dmf_pkg;

  localparam int ID_W    = 32;
  localparam int CNT_W   = 8;
  localparam int TIME_W  = 64;
  localparam int KEEP_W  = 32;
  localparam int RM_W    = 7;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 56;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
  localparam logic [RM_W-1:0]  RM_MAX  = 7'h7F;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 32'd5000;

  typedef enum logic {
    REQ_RECEIVE = 1'b0,
    REQ_SWEEP   = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  rx;
    logic [TIME_W-1:0] tm;
  } entry_t;

endpackage

`default_nettype wire

/* sv/duplicate_message_filter.sv */
// duplicate message filter: table of recent message ids with expiry sweep
`default_nettype none

// Remembers recently received message ids in a table of TABLE_ENTRIES entries
// held in one single-port-read memory. After reset the table is cleared in a
// pass over every entry, during which no item is taken (keep time
// writes are taken at any time). Each item walks the table one entry per
// cycle through the memory read port and one shared subtract/compare unit:
// a receive stops early on a hit, and a sweep walks every entry. The result
// sits in an output register, so the next item may start while it waits to be
// taken.
module duplicate_message_filter
  import dmf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // in_tdata: message_id[31:0], now_time[95:32]
  input  wire logic [IN_W-1:0]   in_tdata,
  // in_tuser: req_type[0]
  input  wire logic              in_tuser,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // out_tdata: is_new[0], reception_count[8:1], ack_id[40:9], table_full[41],
  // removed_count[48:42], zero pad[55:49]
  output logic [OUT_W-1:0]       out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // cfg_tdata: keep_time[31:0]
  input  wire logic [KEEP_W-1:0] cfg_tdata,
  input  wire logic              cfg_tvalid,
  output logic                   cfg_tready
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];
  entry_t mem_q_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd;

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic issue_done_r, issue_done_nxt;
  logic eval_vld_r, eval_vld_nxt;
  logic [IW-1:0] eval_idx_r;
  logic free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [RM_W-1:0] rm_cnt_r, rm_cnt_nxt;
  logic [KEEP_W-1:0] keep_r;

  req_t               type_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  now_r;

  logic               res_new_r, res_new_nxt;
  logic [CNT_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic               res_full_r, res_full_nxt;
  logic [RM_W-1:0]    res_rm_r, res_rm_nxt;

  logic               out_valid_r;
  logic               out_new_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [ID_W-1:0]    out_ack_r;
  logic               out_full_r;
  logic [RM_W-1:0]    out_rm_r;

  logic in_acc, out_free, issuing, finish, load_out;
  logic hit, expired, is_last;
  logic [TIME_W:0] age;
  logic [CNT_W-1:0] rx_inc;
  logic [RM_W-1:0] rm_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign load_out   = (state_r == ST_DONE) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_rm_r, out_full_r, out_ack_r, out_cnt_r, out_new_r};

  // shared compare unit
  assign age     = {1'b0, now_r} - {1'b0, mem_q_r.tm};
  assign expired = mem_q_r.valid && !age[TIME_W] &&
                   (age[TIME_W-1:0] > {{(TIME_W-KEEP_W){1'b0}}, keep_r});
  assign hit     = mem_q_r.valid && (mem_q_r.id == id_r);
  assign is_last = (eval_idx_r == LAST_IDX);
  assign rx_inc  = (mem_q_r.rx == CNT_MAX) ? mem_q_r.rx : mem_q_r.rx + 1'b1;
  assign rm_inc  = (expired && rm_cnt_r != RM_MAX) ? rm_cnt_r + 1'b1 : rm_cnt_r;
  assign issuing = (state_r == ST_SCAN) && !issue_done_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    rm_cnt_nxt     = rm_cnt_r;
    res_new_nxt    = res_new_r;
    res_cnt_nxt    = res_cnt_r;
    res_full_nxt   = res_full_r;
    res_rm_nxt     = res_rm_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = '0;
    finish         = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          free_found_nxt = 1'b0;
          rm_cnt_nxt     = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (eval_vld_r) begin
          if (type_r == REQ_SWEEP) begin
            rm_cnt_nxt = rm_inc;
            if (expired) begin
              mem_we       = 1'b1;
              mem_wa       = eval_idx_r;
              mem_wd       = mem_q_r;
              mem_wd.valid = 1'b0;
            end
            if (is_last) begin
              finish       = 1'b1;
              res_new_nxt  = 1'b0;
              res_cnt_nxt  = '0;
              res_full_nxt = 1'b0;
              res_rm_nxt   = rm_inc;
            end
          end else if (hit) begin
            finish       = 1'b1;
            mem_we       = 1'b1;
            mem_wa       = eval_idx_r;
            mem_wd       = mem_q_r;
            mem_wd.rx    = rx_inc;
            res_new_nxt  = 1'b0;
            res_cnt_nxt  = rx_inc;
            res_full_nxt = 1'b0;
            res_rm_nxt   = '0;
          end else begin
            if (!mem_q_r.valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = eval_idx_r;
            end
            if (is_last) begin
              finish       = 1'b1;
              res_new_nxt  = 1'b1;
              res_cnt_nxt  = CNT_W'(1);
              res_rm_nxt   = '0;
              res_full_nxt = !(free_found_r || !mem_q_r.valid);
              if (free_found_r || !mem_q_r.valid) begin
                mem_we       = 1'b1;
                mem_wa       = free_found_r ? free_idx_r : eval_idx_r;
                mem_wd.valid = 1'b1;
                mem_wd.id    = id_r;
                mem_wd.rx    = CNT_W'(1);
                mem_wd.tm    = now_r;
              end
            end
          end
        end
        if (finish) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign eval_vld_nxt = issuing && !finish;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      eval_vld_r   <= 1'b0;
      free_found_r <= 1'b0;
      rm_cnt_r     <= '0;
      keep_r       <= KEEP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      eval_vld_r   <= eval_vld_nxt;
      free_found_r <= free_found_nxt;
      rm_cnt_r     <= rm_cnt_nxt;
      if (cfg_tvalid && cfg_tready) begin
        keep_r <= cfg_tdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= idx_r;
    free_idx_r <= free_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_full_r <= res_full_nxt;
    res_rm_r   <= res_rm_nxt;
    if (in_acc) begin
      type_r <= req_t'(in_tuser);
      id_r   <= in_tdata[ID_W-1:0];
      now_r  <= in_tdata[ID_W +: TIME_W];
    end
    if (load_out) begin
      out_new_r  <= res_new_r;
      out_cnt_r  <= res_cnt_r;
      out_ack_r  <= (type_r == REQ_SWEEP) ? '0 : id_r;
      out_full_r <= res_full_r;
      out_rm_r   <= res_rm_r;
    end
  end

endmodule

`default_nettype wire

/* sim/duplicate_message_filter_tb.sv */
// testbench for duplicate_message_filter: directed and random traffic checked against a table model
`timescale 1ns / 1ps

typedef struct packed {
  bit        is_new;
  bit [7:0]  count;
  bit [31:0] ack;
  bit        full;
  bit [6:0]  removed;
} verdict_t;

class dedup_scoreboard;
  localparam int SLOTS = 64;

  bit                          slot_valid [SLOTS];
  bit [dmf_pkg::ID_W-1:0]      slot_id    [SLOTS];
  bit [dmf_pkg::CNT_W-1:0]     slot_rx    [SLOTS];
  bit [dmf_pkg::TIME_W-1:0]    slot_time  [SLOTS];
  bit [dmf_pkg::KEEP_W-1:0]    keep_time = dmf_pkg::KEEP_RESET;
  verdict_t                    pending_q[$];

  int errors;
  int checked;
  int n_recv;
  int n_sweep;
  int n_new;
  int n_dup;
  int n_full;
  int n_expired;
  int top_count;

  function int pending();
    return pending_q.size();
  endfunction

  // predict the result of one accepted item and update the table copy
  function void note_input(dmf_pkg::req_t kind, bit [31:0] id, bit [63:0] now);
    verdict_t    v;
    int unsigned gone;
    int          free_slot;
    bit          hit;
    v = '0;
    gone = 0;
    free_slot = -1;
    hit = 1'b0;
    if (kind == dmf_pkg::REQ_SWEEP) begin
      n_sweep++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_time[i] <= now &&
            now - slot_time[i] > {32'd0, keep_time}) begin
          slot_valid[i] = 1'b0;
          gone++;
        end
      end
      v.removed = (gone > dmf_pkg::RM_MAX) ? dmf_pkg::RM_MAX : 7'(gone);
      n_expired += gone;
    end else begin
      n_recv++;
      v.ack = id;
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit) begin
          if (slot_valid[i]) begin
            if (slot_id[i] == id) begin
              hit = 1'b1;
              if (slot_rx[i] != dmf_pkg::CNT_MAX) slot_rx[i]++;
              v.count = slot_rx[i];
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
      end
      if (hit) begin
        n_dup++;
      end else begin
        n_new++;
        v.is_new = 1'b1;
        v.count = 8'd1;
        if (free_slot < 0) begin
          v.full = 1'b1;
          n_full++;
        end else begin
          slot_valid[free_slot] = 1'b1;
          slot_id[free_slot] = id;
          slot_rx[free_slot] = 8'd1;
          slot_time[free_slot] = now;
        end
      end
      if (v.count > top_count) top_count = int'(v.count);
    end
    pending_q.push_back(v);
  endfunction

  task flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t: mismatch in %s of result %0d: got %0h, want %0h",
               $time, field, checked, got, want);
  endtask

  task check_result(logic [dmf_pkg::OUT_W-1:0] d);
    verdict_t w;
    if (pending_q.size() == 0) begin
      flag_mismatch("result with nothing pending", 64'(d), 64'd0);
      return;
    end
    w = pending_q.pop_front();
    checked++;
    if (d[0] !== w.is_new) flag_mismatch("is_new", 64'(d[0]), 64'(w.is_new));
    if (d[8:1] !== w.count) flag_mismatch("reception_count", 64'(d[8:1]), 64'(w.count));
    if (d[40:9] !== w.ack) flag_mismatch("ack_id", 64'(d[40:9]), 64'(w.ack));
    if (d[41] !== w.full) flag_mismatch("table_full", 64'(d[41]), 64'(w.full));
    if (d[48:42] !== w.removed)
      flag_mismatch("removed_count", 64'(d[48:42]), 64'(w.removed));
    if (d[55:49] !== 7'd0) flag_mismatch("padding", 64'(d[55:49]), 64'd0);
  endtask
endclass

module duplicate_message_filter_tb;
  import dmf_pkg::*;

  logic              clk;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;   // message_id[31:0], now_time[95:32]
  logic              in_tuser;   // req_type[0]
  logic              in_tvalid;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;  // is_new, reception_count, ack_id, table_full, removed_count
  logic              out_tvalid;
  logic              out_tready;
  logic [KEEP_W-1:0] cfg_tdata;
  logic              cfg_tvalid;
  logic              cfg_tready;

  dedup_scoreboard sb = new;
  bit              calm;
  bit [63:0]       cur_time;
  int              sink_stall;

  duplicate_message_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_tdata  (cfg_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_item(req_t kind, bit [31:0] id, bit [63:0] now);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {now, id};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(kind, id, now);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(bit [31:0] value);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= value;
    do @(posedge clk); while (cfg_tready !== 1'b1);
    sb.keep_time = value;
    cfg_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // random traffic over a pool of ids with one hot id and a share of sweeps
  task automatic run_mix(int n, int pool_size, int hot_pct, int sweep_pct,
                         int max_step, bit wide);
    bit [31:0] pool[$];
    bit [31:0] id;
    bit [63:0] now;
    req_t      kind;
    int        r;
    for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
    for (int k = 0; k < n; k++) begin
      calm = ((k / 40) % 4 == 3);
      if (wide) begin
        now = {$urandom, $urandom};
      end else begin
        cur_time += 64'($urandom_range(0, max_step));
        r = $urandom_range(0, 99);
        if (r < 3) cur_time += 64'($urandom_range(0, max_step * 50));
        now = cur_time;
        if (r >= 95) now = cur_time - 64'($urandom_range(0, max_step * 4));
      end
      kind = ($urandom_range(0, 99) < sweep_pct) ? REQ_SWEEP : REQ_RECEIVE;
      r = $urandom_range(0, 99);
      if (r < hot_pct) id = pool[0];
      else if (r < 95) id = pool[$urandom_range(0, pool_size - 1)];
      else id = $urandom;
      send_item(kind, id, now);
      if ($urandom_range(0, 199) == 0) drain();
    end
    calm = 1'b0;
  endtask

  // result side: random backpressure and checking
  initial begin
    out_tready <= 1'b0;
    sink_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_result(out_tdata);
      if (calm) begin
        out_tready <= 1'b1;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  initial begin
    #10ms;
    $display("duplicate_message_filter_tb failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= REQ_RECEIVE;
    in_tdata <= '0;
    cfg_tvalid <= 1'b0;
    cfg_tdata <= '0;
    calm = 1'b0;
    cur_time = 64'd1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, keep time at its reset value
    send_item(REQ_RECEIVE, 32'h0000_0000, 64'd0);
    send_item(REQ_RECEIVE, 32'hFFFF_FFFF, 64'd0);
    send_item(REQ_RECEIVE, 32'h0000_0000, 64'd100);
    send_item(REQ_SWEEP, 32'hFFFF_FFFF, 64'd5000);
    send_item(REQ_SWEEP, 32'h0000_0000, 64'd5001);
    send_item(REQ_RECEIVE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(REQ_SWEEP, 32'h0000_0000, 64'd0);
    send_item(REQ_SWEEP, 32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(REQ_RECEIVE, 32'h0000_0005, 64'd10);
    send_item(REQ_RECEIVE, 32'h0000_0000, 64'd3);
    send_item(REQ_RECEIVE, 32'hA5A5_A5A5, 64'h5555_5555_5555_5555);
    send_item(REQ_RECEIVE, 32'h5A5A_5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(REQ_RECEIVE, 32'hA5A5_A5A5, 64'd7);
    send_item(REQ_SWEEP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(REQ_SWEEP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    write_keep(32'd0);
    run_mix(80, 12, 20, 20, 4, 1'b0);
    drain();

    // table fills up, then one far sweep empties it
    write_keep($urandom_range(200, 600));
    run_mix(160, 100, 0, 4, 3, 1'b0);
    send_item(REQ_SWEEP, $urandom, cur_time + 64'd1_000_000);
    cur_time += 64'd1_000_000;
    drain();

    // hot id long enough to saturate its count
    write_keep(32'hFFFF_FFFF);
    run_mix(320, 4, 95, 5, 50, 1'b0);
    drain();

    write_keep($urandom);
    run_mix(80, 8, 10, 25, 1, 1'b1);
    drain();
    repeat (70) @(posedge clk);

    $display("covered %0d receives and %0d sweeps; %0d results checked",
             sb.n_recv, sb.n_sweep, sb.checked);
    $display("%0d new, %0d duplicate, %0d refused on a full table, %0d expired, top count %0d",
             sb.n_new, sb.n_dup, sb.n_full, sb.n_expired, sb.top_count);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("duplicate_message_filter_tb passed");
    end else begin
      $display("duplicate_message_filter_tb failed");
    end
    $finish;
  end
endmodule
